### rtl/core/fqa_pkg.sv
// ----------------------------------------------------------------------------
// fqa_pkg
// shared types and constants of the four-queue aging arbiter
// ----------------------------------------------------------------------------
package fqa_pkg;

    localparam int NUM_Q               = 4;
    localparam int DEFAULT_QUEUE_DEPTH = 16;

    localparam int ID_W    = 16;
    localparam int STAMP_W = 16;
    localparam int ENTRY_W = ID_W + STAMP_W;
    localparam int LIMIT_W = 16;
    localparam int LONG_W  = 5;
    localparam int COUNT_W = 5;
    localparam int CFG_IDX_W = 1;

    // action codes
    localparam logic [1:0] ACT_ARRIVE = 2'd0;
    localparam logic [1:0] ACT_SERVE  = 2'd1;
    localparam logic [1:0] ACT_AGE    = 2'd2;

    // grant rules
    localparam logic [2:0] RULE_STARVE = 3'd0;
    localparam logic [2:0] RULE_LONG   = 3'd1;
    localparam logic [2:0] RULE_STAY   = 3'd2;
    localparam logic [2:0] RULE_MOST   = 3'd3;
    localparam logic [2:0] RULE_NONE   = 3'd4;

    // last served queue, with a code for none
    localparam logic [2:0] DIR_NONE = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STARVE_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LIMIT   = 1'd1;

    localparam logic [LIMIT_W-1:0] STARVE_LIMIT_RESET = 16'd20;
    localparam logic [LONG_W-1:0]  LONG_LIMIT_RESET   = 5'd5;

    // commands from the controller to the datapath
    typedef struct packed {
        logic take_item;
        logic calc_wait;
        logic calc_pick;
        logic commit;
    } fqa_cmd_t;

endpackage

### rtl/core/fqa_ram.sv
// ----------------------------------------------------------------------------
// fqa_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module fqa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/fqa_ctrl.sv
// ----------------------------------------------------------------------------
// fqa_ctrl
// sequencer of the arbiter: take word, wait stage, pick stage, commit
// ----------------------------------------------------------------------------
module fqa_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output fqa_pkg::fqa_cmd_t cmd
);
    import fqa_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WAIT   = 2'd1;
    localparam logic [1:0] ST_PICK   = 2'd2;
    localparam logic [1:0] ST_COMMIT = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    // output register can take a word this cycle
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take_item = 1'b1;
                    state_next    = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                cmd.calc_wait = 1'b1;
                state_next    = ST_PICK;
            end
            ST_PICK:
            begin
                cmd.calc_pick = 1'b1;
                state_next    = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

### rtl/core/fqa_datapath.sv
// ----------------------------------------------------------------------------
// fqa_datapath
// queue stores, pointers, aging clock, grant decision and result register
// ----------------------------------------------------------------------------
module fqa_datapath #(
    parameter int QUEUE_DEPTH = fqa_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  fqa_pkg::fqa_cmd_t              cmd,
    input  logic                           cfg_we,
    input  logic [fqa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fqa_pkg::LIMIT_W-1:0]    cfg_data,
    input  logic [1:0]                     action,
    input  logic [1:0]                     direction,
    input  logic [3:0]                     amount,
    output logic                           accepted,
    output logic                           grant_valid,
    output logic [1:0]                     grant_dir,
    output logic [2:0]                     rule_used,
    output logic [fqa_pkg::ID_W-1:0]       served_id,
    output logic [fqa_pkg::STAMP_W-1:0]    served_wait,
    output logic [fqa_pkg::COUNT_W-1:0]    count_north,
    output logic [fqa_pkg::COUNT_W-1:0]    count_east,
    output logic [fqa_pkg::COUNT_W-1:0]    count_south,
    output logic [fqa_pkg::COUNT_W-1:0]    count_west
);
    import fqa_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int EXT_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    // architectural state
    logic [PTR_W-1:0]   head_reg [NUM_Q];
    logic [PTR_W-1:0]   head_next [NUM_Q];
    logic [PTR_W-1:0]   tail_reg [NUM_Q];
    logic [PTR_W-1:0]   tail_next [NUM_Q];
    logic [CNT_W-1:0]   cnt_reg [NUM_Q];
    logic [CNT_W-1:0]   cnt_next [NUM_Q];
    logic [STAMP_W-1:0] clock_reg, clock_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [2:0]         last_reg, last_next;
    logic [LIMIT_W-1:0] starve_lim_reg;
    logic [LONG_W-1:0]  long_lim_reg;

    // working registers of one word
    logic [1:0]         act_reg;
    logic [1:0]         dir_reg;
    logic [3:0]         amt_reg;
    logic [STAMP_W-1:0] wait_reg [NUM_Q];
    logic [1:0]         pick_reg, pick_next;
    logic [2:0]         rule_reg, rule_next;

    // result register
    logic               acc_out_reg;
    logic               gv_out_reg;
    logic [1:0]         gdir_out_reg;
    logic [2:0]         rule_out_reg;
    logic [ID_W-1:0]    sid_out_reg;
    logic [STAMP_W-1:0] swait_out_reg;
    logic [COUNT_W-1:0] cnt_out_reg [NUM_Q];

    logic [ENTRY_W-1:0] head_entry [NUM_Q];
    logic               push_ok;
    logic               grant;

    assign push_ok = (act_reg == ACT_ARRIVE) && (cnt_reg[dir_reg] < CNT_FULL);
    assign grant   = (act_reg == ACT_SERVE) && (rule_reg != RULE_NONE);

    // one store per queue, read continuously at its head
    for (genvar g = 0; g < NUM_Q; g++)
    begin : g_queue
        fqa_ram #(
            .WIDTH (ENTRY_W),
            .DEPTH (QUEUE_DEPTH)
        ) u_store (
            .clk   (clk),
            .we    (cmd.commit && push_ok && (dir_reg == 2'(g))),
            .waddr (tail_reg[g]),
            .wdata ({id_reg, clock_reg}),
            .raddr (head_reg[g]),
            .rdata (head_entry[g])
        );
    end

    // grant decision from the registered head waits
    always_comb
    begin
        logic [STAMP_W-1:0] best_wait;
        logic               starve_hit;
        logic [1:0]         starve_dir;
        logic [CNT_W-1:0]   best_len;
        logic               long_hit;
        logic [1:0]         long_dir;
        logic               stay_ok;

        best_wait  = '0;
        starve_hit = 1'b0;
        starve_dir = '0;
        best_len   = '0;
        long_hit   = 1'b0;
        long_dir   = '0;
        for (int q = 0; q < NUM_Q; q++)
        begin
            if ((3'(q) != last_reg) && (cnt_reg[q] != '0) && (wait_reg[q] > best_wait))
            begin
                best_wait  = wait_reg[q];
                starve_hit = 1'b1;
                starve_dir = 2'(q);
            end
            if ((3'(q) != last_reg) && (cnt_reg[q] > best_len))
            begin
                best_len = cnt_reg[q];
                long_hit = 1'b1;
                long_dir = 2'(q);
            end
        end
        stay_ok = (last_reg != DIR_NONE) && (cnt_reg[last_reg[1:0]] != '0);

        pick_next = '0;
        rule_next = RULE_NONE;
        priority if (starve_hit && (best_wait > starve_lim_reg))
        begin
            pick_next = starve_dir;
            rule_next = RULE_STARVE;
        end
        else if (long_hit && (EXT_W'(best_len) >= EXT_W'(long_lim_reg)))
        begin
            pick_next = long_dir;
            rule_next = RULE_LONG;
        end
        else if (stay_ok)
        begin
            pick_next = last_reg[1:0];
            rule_next = RULE_STAY;
        end
        else if (long_hit)
        begin
            pick_next = long_dir;
            rule_next = RULE_MOST;
        end
        else
        begin
            pick_next = '0;
            rule_next = RULE_NONE;
        end
    end

    // state update of one word
    always_comb
    begin
        clock_next = clock_reg;
        id_next    = id_reg;
        last_next  = last_reg;
        for (int q = 0; q < NUM_Q; q++)
        begin
            head_next[q] = head_reg[q];
            tail_next[q] = tail_reg[q];
            cnt_next[q]  = cnt_reg[q];
            if (push_ok && (dir_reg == 2'(q)))
            begin
                tail_next[q] = (tail_reg[q] == PTR_LAST) ? '0 : tail_reg[q] + 1'b1;
                cnt_next[q]  = cnt_reg[q] + 1'b1;
            end
            if (grant && (pick_reg == 2'(q)))
            begin
                head_next[q] = (head_reg[q] == PTR_LAST) ? '0 : head_reg[q] + 1'b1;
                cnt_next[q]  = cnt_reg[q] - 1'b1;
            end
        end
        if (push_ok)
        begin
            id_next = id_reg + 1'b1;
        end
        if (grant)
        begin
            clock_next = clock_reg + 1'b1;
            last_next  = {1'b0, pick_reg};
        end
        if (act_reg == ACT_AGE)
        begin
            clock_next = clock_reg + STAMP_W'(amt_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int q = 0; q < NUM_Q; q++)
            begin
                head_reg[q] <= '0;
                tail_reg[q] <= '0;
                cnt_reg[q]  <= '0;
            end
            clock_reg      <= '0;
            id_reg         <= '0;
            last_reg       <= DIR_NONE;
            starve_lim_reg <= STARVE_LIMIT_RESET;
            long_lim_reg   <= LONG_LIMIT_RESET;
        end
        else
        begin
            if (cmd.commit)
            begin
                for (int q = 0; q < NUM_Q; q++)
                begin
                    head_reg[q] <= head_next[q];
                    tail_reg[q] <= tail_next[q];
                    cnt_reg[q]  <= cnt_next[q];
                end
                clock_reg <= clock_next;
                id_reg    <= id_next;
                last_reg  <= last_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_STARVE_LIMIT: starve_lim_reg <= cfg_data;
                    CFG_LONG_LIMIT:   long_lim_reg   <= cfg_data[LONG_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            act_reg <= action;
            dir_reg <= direction;
            amt_reg <= amount;
        end
        if (cmd.calc_wait)
        begin
            for (int q = 0; q < NUM_Q; q++)
            begin
                wait_reg[q] <= clock_reg - head_entry[q][STAMP_W-1:0];
            end
        end
        if (cmd.calc_pick)
        begin
            pick_reg <= pick_next;
            rule_reg <= rule_next;
        end
        if (cmd.commit)
        begin
            acc_out_reg   <= push_ok;
            gv_out_reg    <= grant;
            gdir_out_reg  <= grant ? pick_reg : 2'd0;
            rule_out_reg  <= (act_reg == ACT_SERVE) ? rule_reg : RULE_NONE;
            sid_out_reg   <= grant ? head_entry[pick_reg][ENTRY_W-1:STAMP_W] : '0;
            swait_out_reg <= grant ? wait_reg[pick_reg] : '0;
            for (int q = 0; q < NUM_Q; q++)
            begin
                cnt_out_reg[q] <= COUNT_W'(EXT_W'(cnt_next[q]));
            end
        end
    end

    assign accepted    = acc_out_reg;
    assign grant_valid = gv_out_reg;
    assign grant_dir   = gdir_out_reg;
    assign rule_used   = rule_out_reg;
    assign served_id   = sid_out_reg;
    assign served_wait = swait_out_reg;
    assign count_north = cnt_out_reg[0];
    assign count_east  = cnt_out_reg[1];
    assign count_south = cnt_out_reg[2];
    assign count_west  = cnt_out_reg[3];

endmodule

### rtl/core/four_queue_aging_arbiter_core.sv
// ----------------------------------------------------------------------------
// four_queue_aging_arbiter_core
// aging arbiter over four request queues, one result word per input word
// ----------------------------------------------------------------------------
// per word: the word is taken in idle; the registered head read of the queue
//   stores feeds the wait stage, then the pick stage and commit; in_stall holds
//   off a new word until the word in flight is committed
// a result held by out_stall keeps the block in commit until it is taken
// reset: asynchronous, active low; queues empty, aging clock and id at zero,
//   no queue served yet, starve limit 20, long queue limit 5; store contents
//   are left as they are and no clearing pass runs
module four_queue_aging_arbiter_core #(
    parameter int QUEUE_DEPTH = fqa_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // configuration writes
    input  logic                           cfg_we,
    input  logic [fqa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fqa_pkg::LIMIT_W-1:0]    cfg_data,
    // input word
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     action,
    input  logic [1:0]                     direction,
    input  logic [3:0]                     amount,
    // result word
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           accepted,
    output logic                           grant_valid,
    output logic [1:0]                     grant_dir,
    output logic [2:0]                     rule_used,
    output logic [fqa_pkg::ID_W-1:0]       served_id,
    output logic [fqa_pkg::STAMP_W-1:0]    served_wait,
    output logic [fqa_pkg::COUNT_W-1:0]    count_north,
    output logic [fqa_pkg::COUNT_W-1:0]    count_east,
    output logic [fqa_pkg::COUNT_W-1:0]    count_south,
    output logic [fqa_pkg::COUNT_W-1:0]    count_west
);
    import fqa_pkg::*;

    // commands from the sequencer to the datapath
    fqa_cmd_t cmd;

    // sequencer: one word in flight, result held in the output register
    fqa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // datapath: four queue stores, pointers, counts, aging clock and the
    // grant decision over starvation, long queue, stay and most entries
    fqa_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .action      (action),
        .direction   (direction),
        .amount      (amount),
        .accepted    (accepted),
        .grant_valid (grant_valid),
        .grant_dir   (grant_dir),
        .rule_used   (rule_used),
        .served_id   (served_id),
        .served_wait (served_wait),
        .count_north (count_north),
        .count_east  (count_east),
        .count_south (count_south),
        .count_west  (count_west)
    );

endmodule
